// ===== rtl/banked_flash_command_controller_macros.svh =====
// assertion macros for the banked flash command controller
`ifndef BANKED_FLASH_COMMAND_CONTROLLER_MACROS_SVH
`define BANKED_FLASH_COMMAND_CONTROLLER_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define BFCC_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("flash controller check failed");

// next-cycle implication
`define BFCC_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("flash controller check failed");

`endif

// ===== rtl/bfcc_pkg.sv =====
// shared types and constants for the banked flash command controller
`timescale 1ns / 1ps

package bfcc_pkg;

   localparam int BANK_BYTES   = 65536;
   localparam int SECTOR_BYTES = 4096;
   localparam int NUM_BANKS    = 2;

   localparam int TOTAL_BYTES = BANK_BYTES * NUM_BANKS;
   localparam int ADDR_W      = $clog2(TOTAL_BYTES);
   localparam int BANK_BITS   = $clog2(BANK_BYTES);
   localparam int SECTOR_BITS = $clog2(SECTOR_BYTES);
   // a sector never runs past the end of its bank
   localparam int SECTOR_LEN  = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;

   localparam logic [15:0] CMD_ADDR1 = 16'h5555;
   localparam logic [15:0] CMD_ADDR2 = 16'h2AAA;
   localparam logic [15:0] BANK_ADDR = 16'h0000;
   localparam logic [15:0] ID_ADDR0  = 16'h0000;
   localparam logic [15:0] ID_ADDR1  = 16'h0001;

   localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
   localparam logic [7:0] CMD_ID      = 8'h90;
   localparam logic [7:0] CMD_EXIT    = 8'hF0;
   localparam logic [7:0] CMD_ERASE   = 8'h80;
   localparam logic [7:0] CMD_PROGRAM = 8'hA0;
   localparam logic [7:0] CMD_BANK    = 8'hB0;
   localparam logic [7:0] CMD_CHIP    = 8'h10;
   localparam logic [7:0] CMD_SECTOR  = 8'h30;
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   localparam logic [7:0] RESET_MAKER_ID = 8'h32;
   localparam logic [7:0] RESET_PART_ID  = 8'h1B;

   typedef enum logic [1:0] {
      CSR_LARGE_MODE = 2'd0,
      CSR_MAKER_ID   = 2'd1,
      CSR_PART_ID    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_READY         = 4'd0,
      PH_UNLOCK1       = 4'd1,
      PH_UNLOCK2       = 4'd2,
      PH_ERASE_UNLOCK1 = 4'd3,
      PH_ERASE_UNLOCK2 = 4'd4,
      PH_ERASE         = 4'd5,
      PH_PROGRAM       = 4'd6,
      PH_BANK          = 4'd7,
      PH_ID            = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PROG,
      ST_ERASE,
      ST_HOLD
   } ctrl_state_type;

endpackage

// ===== rtl/banked_flash_command_controller.sv =====
// byte-wide banked flash command controller: sequencer, store memory and response register
`timescale 1ns / 1ps
// Usage
// req_ channel: one bus access per transaction, kind on req_tuser, offset and write byte
// in req_tdata. rsp_ channel: one result per access, read byte and modified flag.
// csr_ channel: register writes (large_mode, maker_id, part_id), always ready.
// Each access passes through the controller states in order; the store memory read is
// registered, and erases sweep the single write port through one byte a cycle:
//   read access                 issue, memory data, result
//   program write               read, write back, result
//   other command writes        command, result
//   sector erase                command, sweep of SECTOR_LEN bytes, result
//   chip erase                  command, sweep of TOTAL_BYTES bytes, result
// After reset all TOTAL_BYTES bytes of the store are swept to 0xFF, while
// req_tready stays low; csr writes are taken throughout.
// A new access is taken while an earlier result still waits on rsp_tready; its own result
// is held internally until the response register frees up, and no further access is
// taken until then.

module banked_flash_command_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] offset, [23:16] wdata
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] rdata, [8] modified, [15:9] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import bfcc_pkg::*;

   ctrl_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic              bank_sel_ff, bank_sel_in;
   logic              changed_ff, changed_in;
   logic              large_mode_ff;
   logic [7:0]        maker_id_ff, part_id_ff;

   logic [15:0]       off_ff, off_in;
   logic [7:0]        wdata_ff, wdata_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_last_ff, sweep_last_in;
   logic [7:0]        res_rdata_ff, res_rdata_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]        rsp_rdata_ff, rsp_rdata_in;
   logic              rsp_modified_ff, rsp_modified_in;

   // store memory, one write and one read port
   logic [7:0]        store_mem [TOTAL_BYTES];
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic [7:0]        mem_rdata_ff;

   logic              req_kind;
   logic [15:0]       req_offset;
   logic [7:0]        req_wdata;
   logic              req_fire;
   logic              rsp_free;
   logic              rd_bank;
   logic [BANK_BITS-1:0] in_bank;
   logic [ADDR_W-1:0] rd_addr, wr_addr, sec_first, sec_last;

   assign req_kind   = req_tuser[0];
   assign req_offset = req_tdata[15:0];
   assign req_wdata  = req_tdata[23:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_modified_ff, rsp_rdata_ff};

   // byte offset inside a bank, then the flat store address
   assign in_bank = req_offset[BANK_BITS-1:0];
   assign rd_bank = large_mode_ff ? bank_sel_ff : 1'b0;
   assign rd_addr = ADDR_W'(32'(rd_bank) * BANK_BYTES + 32'(in_bank));
   assign wr_addr = ADDR_W'(32'(bank_sel_ff) * BANK_BYTES + 32'(in_bank));
   assign sec_first = ADDR_W'(32'(bank_sel_ff) * BANK_BYTES
                              + ((32'(in_bank) >> SECTOR_BITS) << SECTOR_BITS));
   assign sec_last  = ADDR_W'(32'(sec_first) + SECTOR_LEN - 1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         large_mode_ff <= 1'b0;
         maker_id_ff   <= RESET_MAKER_ID;
         part_id_ff    <= RESET_PART_ID;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LARGE_MODE: large_mode_ff <= csr_wdata[0];
            CSR_MAKER_ID:   maker_id_ff   <= csr_wdata;
            CSR_PART_ID:    part_id_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         phase_ff        <= PH_READY;
         bank_sel_ff     <= 1'b0;
         changed_ff      <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
         sweep_addr_ff   <= '0;
         sweep_last_ff   <= ADDR_W'(TOTAL_BYTES - 1);
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         bank_sel_ff     <= bank_sel_in;
         changed_ff      <= changed_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         sweep_addr_ff   <= sweep_addr_in;
         sweep_last_ff   <= sweep_last_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff          <= off_in;
      wdata_ff        <= wdata_in;
      addr_ff         <= addr_in;
      res_rdata_ff    <= res_rdata_in;
      rsp_rdata_ff    <= rsp_rdata_in;
      rsp_modified_ff <= rsp_modified_in;
   end

   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      bank_sel_in     = bank_sel_ff;
      changed_in      = changed_ff;
      off_in          = off_ff;
      wdata_in        = wdata_ff;
      addr_in         = addr_ff;
      sweep_addr_in   = sweep_addr_ff;
      sweep_last_in   = sweep_last_ff;
      res_rdata_in    = res_rdata_ff;
      rsp_rdata_in    = rsp_rdata_ff;
      rsp_modified_in = rsp_modified_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      mem_we          = 1'b0;
      mem_waddr       = sweep_addr_ff;
      mem_wdata       = ERASED_BYTE;
      mem_re          = 1'b0;
      mem_raddr       = rd_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               off_in       = req_offset;
               wdata_in     = req_wdata;
               res_rdata_in = 8'd0;
               state_in     = ST_HOLD;
               if (!req_kind) begin
                  mem_re   = 1'b1;
                  state_in = ST_READ;
               end else begin
                  unique case (phase_ff)
                     PH_READY: begin
                        if (req_offset == CMD_ADDR1 && req_wdata == CMD_UNLOCK1) begin
                           phase_in = PH_UNLOCK1;
                        end
                     end
                     PH_UNLOCK1: begin
                        phase_in = (req_offset == CMD_ADDR2 && req_wdata == CMD_UNLOCK2)
                                   ? PH_UNLOCK2 : PH_READY;
                     end
                     PH_UNLOCK2: begin
                        phase_in = PH_READY;
                        if (req_offset == CMD_ADDR1) begin
                           priority if (req_wdata == CMD_ID) begin
                              phase_in = PH_ID;
                           end else if (req_wdata == CMD_ERASE) begin
                              phase_in = PH_ERASE_UNLOCK1;
                           end else if (req_wdata == CMD_PROGRAM) begin
                              phase_in = PH_PROGRAM;
                           end else if (req_wdata == CMD_BANK) begin
                              phase_in = PH_BANK;
                           end else begin
                              phase_in = PH_READY;
                           end
                        end
                     end
                     PH_ERASE_UNLOCK1: begin
                        phase_in = (req_offset == CMD_ADDR1 && req_wdata == CMD_UNLOCK1)
                                   ? PH_ERASE_UNLOCK2 : PH_READY;
                     end
                     PH_ERASE_UNLOCK2: begin
                        phase_in = (req_offset == CMD_ADDR2 && req_wdata == CMD_UNLOCK2)
                                   ? PH_ERASE : PH_READY;
                     end
                     PH_ERASE: begin
                        phase_in = PH_READY;
                        priority if (req_offset == CMD_ADDR1 && req_wdata == CMD_CHIP) begin
                           changed_in    = 1'b1;
                           sweep_addr_in = '0;
                           sweep_last_in = ADDR_W'(TOTAL_BYTES - 1);
                           state_in      = ST_ERASE;
                        end else if (req_wdata == CMD_SECTOR) begin
                           changed_in    = 1'b1;
                           sweep_addr_in = sec_first;
                           sweep_last_in = sec_last;
                           state_in      = ST_ERASE;
                        end else begin
                           state_in = ST_HOLD;
                        end
                     end
                     PH_PROGRAM: begin
                        // read the old byte, and write it back in the next cycle
                        phase_in  = PH_READY;
                        mem_re    = 1'b1;
                        mem_raddr = wr_addr;
                        addr_in   = wr_addr;
                        state_in  = ST_PROG;
                     end
                     PH_BANK: begin
                        phase_in = PH_READY;
                        if (req_offset == BANK_ADDR) begin
                           bank_sel_in = (NUM_BANKS > 1) ? req_wdata[0] : 1'b0;
                        end
                     end
                     PH_ID: begin
                        priority if (req_offset == CMD_ADDR1 && req_wdata == CMD_UNLOCK1) begin
                           phase_in = PH_UNLOCK1;
                        end else if (req_wdata == CMD_EXIT) begin
                           phase_in = PH_READY;
                        end else begin
                           phase_in = PH_ID;
                        end
                     end
                     default: phase_in = PH_READY;
                  endcase
               end
            end
         end

         ST_READ: begin
            state_in = ST_HOLD;
            priority if (phase_ff == PH_ID && off_ff == ID_ADDR0) begin
               res_rdata_in = maker_id_ff;
            end else if (phase_ff == PH_ID && off_ff == ID_ADDR1) begin
               res_rdata_in = part_id_ff;
            end else begin
               res_rdata_in = mem_rdata_ff;
            end
         end

         ST_PROG: begin
            mem_we     = 1'b1;
            mem_waddr  = addr_ff;
            mem_wdata  = mem_rdata_ff & wdata_ff;
            changed_in = 1'b1;
            state_in   = ST_HOLD;
         end

         ST_ERASE: begin
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = ST_HOLD;
            end
         end

         ST_HOLD: begin
            if (rsp_free) begin
               rsp_tvalid_in   = 1'b1;
               rsp_rdata_in    = res_rdata_ff;
               rsp_modified_in = changed_ff;
               state_in        = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

`include "banked_flash_command_controller_macros.svh"

   // no access is taken while the store is being swept
   `BFCC_ASSERT_IMP(a_no_accept_in_sweep,
                    state_ff == ST_CLEAR || state_ff == ST_ERASE, !req_tready)
   // the modified flag never falls outside reset
   `BFCC_ASSERT_NXT(a_changed_sticky, changed_ff, changed_ff)
   // the store is written only by a program write-back or a sweep
   `BFCC_ASSERT_IMP(a_write_source, mem_we,
                    state_ff == ST_PROG || state_ff == ST_CLEAR || state_ff == ST_ERASE)
   // a program write-back always ends in the result stage
   `BFCC_ASSERT_NXT(a_prog_to_hold, state_ff == ST_PROG, state_ff == ST_HOLD)

endmodule
